>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the sequencer RTL of the MLP step block.
// Needs signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked out of reset
`define CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> hw/rtl/mlpbp_pkg.sv
// Package for the 2-2-2 sigmoid MLP step block: types, step codes,
// rounding helpers and the sigmoid lookup table. No dependencies.
`timescale 1ns / 1ps

package mlpbp_pkg;

  localparam int SIGMOID_TABLE_ENTRIES = 256;
  localparam int SIG_IW = $clog2(SIGMOID_TABLE_ENTRIES);
  localparam int SIG_PW = 17 + SIG_IW + 1;

  typedef logic [12:0] sig_lut_t [SIGMOID_TABLE_ENTRIES];

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LRATE = 2'd0;
  localparam logic [1:0] REG_HBIAS = 2'd1;
  localparam logic [1:0] REG_OBIAS = 2'd2;

  // Micro-steps of the sequencer
  typedef logic [5:0] step_t;
  localparam step_t ST_H0A = 6'd0;
  localparam step_t ST_H0B = 6'd1;
  localparam step_t ST_H0C = 6'd2;
  localparam step_t ST_H0D = 6'd3;
  localparam step_t ST_H1B = 6'd4;
  localparam step_t ST_H1C = 6'd5;
  localparam step_t ST_H1D = 6'd6;
  localparam step_t ST_O0A = 6'd7;
  localparam step_t ST_O0B = 6'd8;
  localparam step_t ST_O0C = 6'd9;
  localparam step_t ST_O0D = 6'd10;
  localparam step_t ST_O1B = 6'd11;
  localparam step_t ST_O1C = 6'd12;
  localparam step_t ST_O1D = 6'd13;
  localparam step_t ST_D0A = 6'd14;
  localparam step_t ST_D0B = 6'd15;
  localparam step_t ST_D0C = 6'd16;
  localparam step_t ST_D1B = 6'd17;
  localparam step_t ST_D1C = 6'd18;
  localparam step_t ST_E0A = 6'd19;
  localparam step_t ST_E0B = 6'd20;
  localparam step_t ST_E0C = 6'd21;
  localparam step_t ST_E0D = 6'd22;
  localparam step_t ST_E0E = 6'd23;
  localparam step_t ST_E1A = 6'd24;
  localparam step_t ST_E1B = 6'd25;
  localparam step_t ST_E1C = 6'd26;
  localparam step_t ST_E1D = 6'd27;
  localparam step_t ST_E1E = 6'd28;
  localparam step_t ST_I0A = 6'd29;
  localparam step_t ST_I0B = 6'd30;
  localparam step_t ST_I0C = 6'd31;
  localparam step_t ST_I0D = 6'd32;
  localparam step_t ST_I1B = 6'd33;
  localparam step_t ST_I1C = 6'd34;
  localparam step_t ST_I1D = 6'd35;
  localparam step_t ST_W0A = 6'd36;
  localparam step_t ST_W0B = 6'd37;
  localparam step_t ST_W0C = 6'd38;
  localparam step_t ST_W0D = 6'd39;
  localparam step_t ST_W1B = 6'd40;
  localparam step_t ST_W1C = 6'd41;
  localparam step_t ST_W1D = 6'd42;

  // Sequencer to datapath control
  typedef struct packed {
    logic  start;
    logic  run;
    step_t step;
  } ctl_t;

  // Round half up, drop 12 fraction bits
  function automatic logic signed [34:0] rnd12(input logic signed [34:0] v);
    return (v + 35'sd2048) >>> 12;
  endfunction

  // Round half up, drop 24 fraction bits
  function automatic logic signed [56:0] rnd24(input logic signed [56:0] v);
    return (v + 57'sd8388608) >>> 24;
  endfunction

  // Clamp to 16 bit signed
  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    if (v > 35'sd32767) return 16'sh7fff;
    if (v < -35'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic ovf16(input logic signed [34:0] v);
    return (v > 35'sd32767) || (v < -35'sd32768);
  endfunction

  // Table index of a clamped sum
  function automatic logic [SIG_IW-1:0] sig_index(input logic signed [15:0] z);
    logic [SIG_PW-1:0] prod;
    prod = SIG_PW'({1'b0, z ^ 16'h8000}) * SIG_PW'(SIGMOID_TABLE_ENTRIES);
    return prod[16 +: SIG_IW];
  endfunction

  // Build the sigmoid table at elaboration: series exp then 8 squarings
  function automatic sig_lut_t build_lut();
    sig_lut_t lut;
    longint   one;
    longint   zq, a, u, u2, u3, u4, e, den, num, rem, q;
    one = longint'(1) << 30;
    for (int i = 0; i < SIGMOID_TABLE_ENTRIES; i++) begin
      zq = -32768 + (longint'(2 * i + 1) * 32768) / SIGMOID_TABLE_ENTRIES;
      a  = (zq < 0) ? -zq : zq;
      u  = a << 10;
      u2 = (u * u) >> 30;
      u3 = (u2 * u) >> 30;
      u4 = (u3 * u) >> 30;
      e  = one - u + u2 / 2 - u3 / 6 + u4 / 24;
      for (int k = 0; k < 8; k++) e = (e * e + (one >> 1)) >> 30;
      den = one + e;
      num = (longint'(4096) << 30) + (den >> 1);
      rem = 0;
      q   = 0;
      for (int b = 43; b >= 0; b--) begin
        rem = (rem << 1) | ((num >> b) & 1);
        if (rem >= den) begin
          rem = rem - den;
          q   = q | (longint'(1) << b);
        end
      end
      lut[i] = (zq < 0) ? 13'(4096 - q) : 13'(q);
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_lut();

endpackage

>>> hw/rtl/mlpbp_mul.sv
// Shared signed multiplier with registered product.
// Depends on nothing but the clock.
`timescale 1ns / 1ps

module mlpbp_mul (
  input  logic               clk,
  input  logic signed [32:0] opa,
  input  logic signed [23:0] opb,
  output logic signed [56:0] prod
);

  logic signed [56:0] prod_r;

  // Register every product before it is used
  always_ff @(posedge clk) begin
    prod_r <= 57'(opa) * 57'(opb);
  end

  assign prod = prod_r;

endmodule

>>> hw/rtl/mlpbp_ctrl.sv
// Sequencer of the MLP step block: handshake FSM and micro-step counter.
// Depends on mlpbp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlpbp_ctrl
  import mlpbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic train,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } fsm_t;

  fsm_t  state_r, state_nxt;
  step_t step_r, step_nxt;
  logic  start;
  logic  last;

  assign start = in_valid && (state_r == S_IDLE);
  assign last  = ((step_r == ST_O1D) && !train) || (step_r == ST_W1D);

  // Advance through the steps, then hold the result until transfer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          step_nxt  = ST_H0A;
        end
      end
      S_RUN: begin
        if (last) state_nxt = S_DONE;
        else step_nxt = step_r + 6'd1;
      end
      S_DONE: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_H0A;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign ctl.start = start;
  assign ctl.run   = (state_r == S_RUN);
  assign ctl.step  = step_r;

  `CHK_NXT(a_start_first_step, start, (state_r == S_RUN) && (step_r == ST_H0A))
  `CHK_IMP(a_done_at_last_step, state_r == S_DONE, (step_r == ST_O1D) || (step_r == ST_W1D))
  `CHK_NXT(a_transfer_to_idle, out_valid && !out_stall, state_r == S_IDLE)

endmodule

>>> hw/rtl/mlp_2x2x2_backprop_step.sv
// Top level of the 2-2-2 sigmoid MLP step: datapath registers, config port.
// Depends on mlpbp_pkg, mlpbp_ctrl and mlpbp_mul.
`timescale 1ns / 1ps
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+---------------------
//  input   | in_valid/in_stall, in_x_*, in_target_*,  | in_valid & !in_stall
//          | in_train                                |
//  result  | out_valid/out_stall, out_first,         | out_valid & !out_stall
//          | out_second, out_saturated               |
//  config  | psel/penable/pwrite/paddr/pwdata/prdata | psel & penable & pwrite
//
//  One sample runs 14 micro-steps on the shared multiplier for inference and
//  43 when training; the result then stays valid until it is transferred.
//  The single shared multiplier sets how long a sample takes.
//  Reset (synchronous, rst_n low) restores weights, flag, config and sequencer.
//  in_stall is high from accept until the result has been transferred.

module mlp_2x2x2_backprop_step
  import mlpbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_x_first,
  input  logic signed [15:0] in_x_second,
  input  logic [12:0]        in_target_first,
  input  logic [12:0]        in_target_second,
  input  logic               in_train,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [12:0]        out_first,
  output logic [12:0]        out_second,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  ctl_t ctl;

  logic [14:0]        lrate_r;
  logic signed [15:0] hbias_r, obias_r;
  logic signed [15:0] wi_r [4];
  logic signed [15:0] wo_r [4];
  logic signed [15:0] x0_r, x1_r;
  logic [12:0]        t0_r, t1_r;
  logic               train_r;
  logic [12:0]        y0_r, y1_r, o0_r, o1_r;
  logic signed [13:0] d0_r, d1_r;
  logic signed [17:0] e_r;
  logic signed [15:0] g0_r, g1_r;
  logic signed [15:0] z_r;
  logic signed [33:0] acc_r;
  logic signed [32:0] lrg_r;
  logic               sat_r;

  logic signed [32:0] opa;
  logic signed [23:0] opb;
  logic signed [56:0] prod;

  logic signed [34:0] sum35;
  logic signed [34:0] esum;
  logic signed [34:0] zsum;
  logic signed [15:0] bias;
  logic signed [56:0] r24;
  logic signed [34:0] wsel;
  logic signed [34:0] wdiff;
  logic signed [15:0] wnew;
  logic               wovf;
  logic [12:0]        sig_y;
  logic               cfg_wr;

  mlpbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .train     (train_r),
    .ctl       (ctl)
  );

  mlpbp_mul u_mul (
    .clk  (clk),
    .opa  (opa),
    .opb  (opb),
    .prod (prod)
  );

  // Select multiplier operands for the current step
  always_comb begin
    opa = '0;
    opb = '0;
    case (ctl.step)
      ST_H0A: begin opa = 33'(x0_r); opb = 24'(wi_r[0]); end
      ST_H0B: begin opa = 33'(x1_r); opb = 24'(wi_r[2]); end
      ST_H0D: begin opa = 33'(x0_r); opb = 24'(wi_r[1]); end
      ST_H1B: begin opa = 33'(x1_r); opb = 24'(wi_r[3]); end
      ST_O0A: begin opa = 33'({1'b0, y0_r}); opb = 24'(wo_r[0]); end
      ST_O0B: begin opa = 33'({1'b0, y1_r}); opb = 24'(wo_r[2]); end
      ST_O0D: begin opa = 33'({1'b0, y0_r}); opb = 24'(wo_r[1]); end
      ST_O1B: begin opa = 33'({1'b0, y1_r}); opb = 24'(wo_r[3]); end
      ST_D0A: begin opa = 33'({1'b0, o0_r}); opb = 24'({1'b0, 13'd4096 - o0_r}); end
      ST_D0B: begin
        opa = 33'($signed({1'b0, o0_r}) - $signed({1'b0, t0_r}));
        opb = $signed(prod[23:0]);
      end
      ST_D0C: begin opa = 33'({1'b0, o1_r}); opb = 24'({1'b0, 13'd4096 - o1_r}); end
      ST_D1B: begin
        opa = 33'($signed({1'b0, o1_r}) - $signed({1'b0, t1_r}));
        opb = $signed(prod[23:0]);
      end
      ST_E0A: begin opa = 33'(d0_r); opb = 24'(wo_r[0]); end
      ST_E0B: begin opa = 33'(d1_r); opb = 24'(wo_r[1]); end
      ST_E0C: begin opa = 33'({1'b0, y0_r}); opb = 24'({1'b0, 13'd4096 - y0_r}); end
      ST_E0D: begin opa = 33'(e_r); opb = $signed(prod[23:0]); end
      ST_E1A: begin opa = 33'(d0_r); opb = 24'(wo_r[2]); end
      ST_E1B: begin opa = 33'(d1_r); opb = 24'(wo_r[3]); end
      ST_E1C: begin opa = 33'({1'b0, y1_r}); opb = 24'({1'b0, 13'd4096 - y1_r}); end
      ST_E1D: begin opa = 33'(e_r); opb = $signed(prod[23:0]); end
      ST_I0A: begin opa = 33'(g0_r); opb = 24'({1'b0, lrate_r}); end
      ST_I0B: begin opa = $signed(prod[32:0]); opb = 24'(x0_r); end
      ST_I0C: begin opa = lrg_r; opb = 24'(x1_r); end
      ST_I0D: begin opa = 33'(g1_r); opb = 24'({1'b0, lrate_r}); end
      ST_I1B: begin opa = $signed(prod[32:0]); opb = 24'(x0_r); end
      ST_I1C: begin opa = lrg_r; opb = 24'(x1_r); end
      ST_W0A: begin opa = 33'(d0_r); opb = 24'({1'b0, lrate_r}); end
      ST_W0B: begin opa = $signed(prod[32:0]); opb = 24'({1'b0, y0_r}); end
      ST_W0C: begin opa = lrg_r; opb = 24'({1'b0, y1_r}); end
      ST_W0D: begin opa = 33'(d1_r); opb = 24'({1'b0, lrate_r}); end
      ST_W1B: begin opa = $signed(prod[32:0]); opb = 24'({1'b0, y0_r}); end
      ST_W1C: begin opa = lrg_r; opb = 24'({1'b0, y1_r}); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Pair sum, rounded and biased network sum, and table read
  assign sum35 = 35'(acc_r) + 35'($signed(prod[33:0]));
  assign esum  = rnd12(sum35);
  assign bias  = (ctl.step == ST_H0C || ctl.step == ST_H1C) ? hbias_r : obias_r;
  assign zsum  = rnd12(sum35) + 35'(bias);
  assign sig_y = SIG_LUT[sig_index(z_r)];
  assign r24   = rnd24(prod);

  // Weight being updated in this step
  always_comb begin
    case (ctl.step)
      ST_I0C: wsel = 35'(wi_r[0]);
      ST_I0D: wsel = 35'(wi_r[2]);
      ST_I1C: wsel = 35'(wi_r[1]);
      ST_I1D: wsel = 35'(wi_r[3]);
      ST_W0C: wsel = 35'(wo_r[0]);
      ST_W0D: wsel = 35'(wo_r[2]);
      ST_W1C: wsel = 35'(wo_r[1]);
      ST_W1D: wsel = 35'(wo_r[3]);
      default: wsel = '0;
    endcase
  end

  assign wdiff = wsel - r24[34:0];
  assign wnew  = sat16(wdiff);
  assign wovf  = ovf16(wdiff);

  // Datapath registers, written by step
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x0_r    <= in_x_first;
      x1_r    <= in_x_second;
      t0_r    <= in_target_first;
      t1_r    <= in_target_second;
      train_r <= in_train;
    end
    if (ctl.run) begin
      case (ctl.step)
        ST_H0B, ST_H1B, ST_O0B, ST_O1B, ST_E0B, ST_E1B: acc_r <= $signed(prod[33:0]);
        ST_H0C, ST_H1C, ST_O0C, ST_O1C: z_r <= sat16(zsum);
        ST_H0D: y0_r <= sig_y;
        ST_H1D: y1_r <= sig_y;
        ST_O0D: o0_r <= sig_y;
        ST_O1D: o1_r <= sig_y;
        ST_D0C: d0_r <= r24[13:0];
        ST_D1C: d1_r <= r24[13:0];
        ST_E0C, ST_E1C: e_r <= esum[17:0];
        ST_E0E: g0_r <= r24[15:0];
        ST_E1E: g1_r <= r24[15:0];
        ST_I0B, ST_I1B, ST_W0B, ST_W1B: lrg_r <= $signed(prod[32:0]);
        default: ;
      endcase
    end
  end

  // Weights, flag and configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r[0] <= 16'sd614;
      wi_r[1] <= 16'sd1024;
      wi_r[2] <= 16'sd819;
      wi_r[3] <= 16'sd1229;
      wo_r[0] <= 16'sd1638;
      wo_r[1] <= 16'sd2048;
      wo_r[2] <= 16'sd1843;
      wo_r[3] <= 16'sd2253;
      sat_r   <= 1'b0;
      lrate_r <= 15'd2048;
      hbias_r <= 16'sd1434;
      obias_r <= 16'sd2458;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_LRATE: lrate_r <= pwdata[14:0];
          REG_HBIAS: hbias_r <= $signed(pwdata[15:0]);
          REG_OBIAS: obias_r <= $signed(pwdata[15:0]);
          default: ;
        endcase
      end
      if (ctl.start) sat_r <= 1'b0;
      if (ctl.run) begin
        case (ctl.step)
          ST_I0C: wi_r[0] <= wnew;
          ST_I0D: wi_r[2] <= wnew;
          ST_I1C: wi_r[1] <= wnew;
          ST_I1D: wi_r[3] <= wnew;
          ST_W0C: wo_r[0] <= wnew;
          ST_W0D: wo_r[2] <= wnew;
          ST_W1C: wo_r[1] <= wnew;
          ST_W1D: wo_r[3] <= wnew;
          default: ;
        endcase
        case (ctl.step)
          ST_I0C, ST_I0D, ST_I1C, ST_I1D, ST_W0C, ST_W0D, ST_W1C, ST_W1D:
            if (wovf) sat_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Register read back
  always_comb begin
    case (paddr[3:2])
      REG_LRATE: prdata = 32'({17'd0, lrate_r});
      REG_HBIAS: prdata = 32'(hbias_r);
      REG_OBIAS: prdata = 32'(obias_r);
      default:   prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign out_first     = o0_r;
  assign out_second    = o1_r;
  assign out_saturated = sat_r;

endmodule
